// ===== hw/rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the path RTO / cwnd control unit
// Config struct, beat payload structs, command codes and saturation helpers.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Variance floor used when the estimator lands on zero
  localparam logic [31:0] CLOCK_GRANULARITY = 32'd1;

  localparam int unsigned CFG_AW = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ALPHA_SHIFT      = 3'd0;
  localparam logic [2:0] REG_BETA_SHIFT       = 3'd1;
  localparam logic [2:0] REG_RTO_FLOOR        = 3'd2;
  localparam logic [2:0] REG_RTO_CEILING      = 3'd3;
  localparam logic [2:0] REG_INITIAL_RTO      = 3'd4;
  localparam logic [2:0] REG_PATH_MTU         = 3'd5;
  localparam logic [2:0] REG_INITIAL_CWND     = 3'd6;
  localparam logic [2:0] REG_INITIAL_SSTHRESH = 3'd7;

  // Reset values
  localparam logic [4:0]  RST_ALPHA_SHIFT      = 5'd3;
  localparam logic [4:0]  RST_BETA_SHIFT       = 5'd2;
  localparam logic [31:0] RST_RTO_FLOOR        = 32'd1000;
  localparam logic [31:0] RST_RTO_CEILING      = 32'd60000;
  localparam logic [31:0] RST_INITIAL_RTO      = 32'd3000;
  localparam logic [15:0] RST_PATH_MTU         = 16'd1500;
  localparam logic [31:0] RST_INITIAL_CWND     = 32'd4380;
  localparam logic [31:0] RST_INITIAL_SSTHRESH = 32'd65535;

  typedef enum logic [2:0] {
    CMD_RTT_SAMPLE = 3'd0,
    CMD_SACK       = 3'd1,
    CMD_T3_EXPIRY  = 3'd2,
    CMD_FAST_RTX   = 3'd3,
    CMD_ECN_ECHO   = 3'd4,
    CMD_INACTIVITY = 3'd5
  } prc_cmd_t;

  typedef struct packed {
    logic [4:0]  alpha_shift;
    logic [4:0]  beta_shift;
    logic [31:0] rto_floor;
    logic [31:0] rto_ceiling;
    logic [31:0] initial_rto;
    logic [15:0] path_mtu;
    logic [31:0] initial_cwnd;
    logic [31:0] initial_ssthresh;
  } prc_cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] rtt_value;
    logic [31:0] sack_cum_tsn;
    logic [31:0] ack_point;
    logic [31:0] newly_acked;
    logic [31:0] outstanding;
    logic [31:0] now;
    logic [31:0] last_used_time;
  } prc_item_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [31:0] pba;
    logic [31:0] rto;
    logic [31:0] srtt;
    logic [31:0] rttvar;
  } prc_res_t;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // old - old/2^sh + sample/2^sh, saturated
  function automatic logic [31:0] ewma(input logic [31:0] old_v,
                                       input logic [31:0] sample,
                                       input logic [4:0]  sh);
    logic [32:0] t;
    t = {1'b0, old_v} - {1'b0, old_v >> sh} + {1'b0, sample >> sh};
    return sat32(t);
  endfunction

endpackage

// ===== hw/rtl/prc_cfg.sv =====
// ----------------------------------------------------------------------------
// prc_cfg: configuration register file
// APB-style slave, zero wait states, eight 32-bit word registers.
// ----------------------------------------------------------------------------
module prc_cfg import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output prc_cfg_t          cfg
);

  prc_cfg_t    cfg_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_shift      <= RST_ALPHA_SHIFT;
      cfg_r.beta_shift       <= RST_BETA_SHIFT;
      cfg_r.rto_floor        <= RST_RTO_FLOOR;
      cfg_r.rto_ceiling      <= RST_RTO_CEILING;
      cfg_r.initial_rto      <= RST_INITIAL_RTO;
      cfg_r.path_mtu         <= RST_PATH_MTU;
      cfg_r.initial_cwnd     <= RST_INITIAL_CWND;
      cfg_r.initial_ssthresh <= RST_INITIAL_SSTHRESH;
    end else if (wr_en) begin
      case (idx)
        REG_ALPHA_SHIFT:      cfg_r.alpha_shift      <= pwdata[4:0];
        REG_BETA_SHIFT:       cfg_r.beta_shift       <= pwdata[4:0];
        REG_RTO_FLOOR:        cfg_r.rto_floor        <= pwdata;
        REG_RTO_CEILING:      cfg_r.rto_ceiling      <= pwdata;
        REG_INITIAL_RTO:      cfg_r.initial_rto      <= pwdata;
        REG_PATH_MTU:         cfg_r.path_mtu         <= pwdata[15:0];
        REG_INITIAL_CWND:     cfg_r.initial_cwnd     <= pwdata;
        REG_INITIAL_SSTHRESH: cfg_r.initial_ssthresh <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA_SHIFT:      prdata = {27'd0, cfg_r.alpha_shift};
      REG_BETA_SHIFT:       prdata = {27'd0, cfg_r.beta_shift};
      REG_RTO_FLOOR:        prdata = cfg_r.rto_floor;
      REG_RTO_CEILING:      prdata = cfg_r.rto_ceiling;
      REG_INITIAL_RTO:      prdata = cfg_r.initial_rto;
      REG_PATH_MTU:         prdata = {16'd0, cfg_r.path_mtu};
      REG_INITIAL_CWND:     prdata = cfg_r.initial_cwnd;
      REG_INITIAL_SSTHRESH: prdata = cfg_r.initial_ssthresh;
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/prc_core.sv =====
// ----------------------------------------------------------------------------
// prc_core: per-path state and single-pass update logic
// Holds SRTT/RTTVAR/RTO and cwnd/ssthresh/pba; applies one event per step.
// ----------------------------------------------------------------------------
module prc_core import prc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  prc_item_t item,
  input  prc_cfg_t  cfg,
  output prc_res_t  res
);

  logic [31:0] srtt_r, rttvar_r, last_rtt_r, rto_r;
  logic [31:0] cwnd_r, ssthresh_r, pba_r, ecn_time_r;
  logic [31:0] srtt_nxt, rttvar_nxt, last_rtt_nxt, rto_nxt;
  logic [31:0] cwnd_nxt, ssthresh_nxt, pba_nxt, ecn_time_nxt;

  // RTT estimator
  logic        first_sample;
  logic [31:0] diff, srtt_e, var_e, var_f;
  logic [34:0] rto_sum;
  logic [31:0] rto_sat, rto_lo, rto_c;

  // window
  logic        sack_ok;
  logic [31:0] ss_step, ss_cwnd, ca_pba, ca_cwnd, ca_pba_left;
  logic [31:0] half_cwnd, two_mtu, red_thr;
  logic [31:0] ecn_elapsed, idle_elapsed;

  always_comb begin
    first_sample = (rttvar_r == 32'd0) && (srtt_r == 32'd0);
    diff   = (srtt_r >= item.rtt_value) ? srtt_r - item.rtt_value
                                        : item.rtt_value - srtt_r;
    var_e  = first_sample ? (item.rtt_value >> 1)
                          : ewma(rttvar_r, diff, cfg.beta_shift);
    srtt_e = first_sample ? item.rtt_value
                          : ewma(srtt_r, item.rtt_value, cfg.alpha_shift);
    var_f  = (var_e == 32'd0) ? CLOCK_GRANULARITY : var_e;
    rto_sum = {3'b000, srtt_e} + {1'b0, var_f, 2'b00};
    rto_sat = (rto_sum[34:32] != 3'b000) ? 32'hFFFF_FFFF : rto_sum[31:0];
    // floor first, ceiling wins
    rto_lo  = (rto_sat < cfg.rto_floor) ? cfg.rto_floor : rto_sat;
    rto_c   = (rto_lo > cfg.rto_ceiling) ? cfg.rto_ceiling : rto_lo;
  end

  always_comb begin
    sack_ok = (item.ack_point < item.sack_cum_tsn) && (item.outstanding >= cwnd_r);
    ss_step = (item.newly_acked > {16'd0, cfg.path_mtu}) ? {16'd0, cfg.path_mtu}
                                                         : item.newly_acked;
    ss_cwnd = sat32({1'b0, cwnd_r} + {1'b0, ss_step});
    ca_pba  = sat32({1'b0, pba_r} + {1'b0, item.newly_acked});
    ca_cwnd = sat32({1'b0, cwnd_r} + {17'd0, cfg.path_mtu});
    ca_pba_left = (ca_cwnd < ca_pba) ? ca_pba - ca_cwnd : 32'd0;

    half_cwnd = cwnd_r >> 1;
    two_mtu   = {15'd0, cfg.path_mtu, 1'b0};
    red_thr   = (half_cwnd > two_mtu) ? half_cwnd : two_mtu;

    ecn_elapsed  = item.now - ecn_time_r;
    idle_elapsed = item.now - item.last_used_time;
  end

  always_comb begin
    srtt_nxt     = srtt_r;
    rttvar_nxt   = rttvar_r;
    last_rtt_nxt = last_rtt_r;
    rto_nxt      = rto_r;
    cwnd_nxt     = cwnd_r;
    ssthresh_nxt = ssthresh_r;
    pba_nxt      = pba_r;
    ecn_time_nxt = ecn_time_r;
    case (item.command)
      CMD_RTT_SAMPLE: begin
        srtt_nxt     = srtt_e;
        rttvar_nxt   = var_f;
        rto_nxt      = rto_c;
        last_rtt_nxt = item.rtt_value;
      end
      CMD_SACK: begin
        if (sack_ok) begin
          if (cwnd_r <= ssthresh_r) begin
            cwnd_nxt = ss_cwnd;
          end else if (ca_pba >= cwnd_r) begin
            cwnd_nxt = ca_cwnd;
            pba_nxt  = ca_pba_left;
          end else begin
            pba_nxt  = ca_pba;
          end
        end
      end
      CMD_T3_EXPIRY: begin
        ssthresh_nxt = red_thr;
        cwnd_nxt     = {16'd0, cfg.path_mtu};
        pba_nxt      = 32'd0;
      end
      CMD_FAST_RTX: begin
        ssthresh_nxt = red_thr;
        cwnd_nxt     = red_thr;
        pba_nxt      = 32'd0;
      end
      CMD_ECN_ECHO: begin
        // at most one cut per last RTT
        if (ecn_elapsed > last_rtt_r) begin
          ssthresh_nxt = red_thr;
          cwnd_nxt     = red_thr;
          ecn_time_nxt = item.now;
        end
        pba_nxt = 32'd0;
      end
      CMD_INACTIVITY: begin
        if (idle_elapsed > rto_r) begin
          cwnd_nxt = two_mtu;
        end
        pba_nxt = 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r     <= 32'd0;
      rttvar_r   <= 32'd0;
      last_rtt_r <= 32'd0;
      rto_r      <= RST_INITIAL_RTO;
      cwnd_r     <= RST_INITIAL_CWND;
      ssthresh_r <= RST_INITIAL_SSTHRESH;
      pba_r      <= 32'd0;
      ecn_time_r <= 32'd0;
    end else if (step) begin
      srtt_r     <= srtt_nxt;
      rttvar_r   <= rttvar_nxt;
      last_rtt_r <= last_rtt_nxt;
      rto_r      <= rto_nxt;
      cwnd_r     <= cwnd_nxt;
      ssthresh_r <= ssthresh_nxt;
      pba_r      <= pba_nxt;
      ecn_time_r <= ecn_time_nxt;
    end
  end

  assign res.cwnd     = cwnd_nxt;
  assign res.ssthresh = ssthresh_nxt;
  assign res.pba      = pba_nxt;
  assign res.rto      = rto_nxt;
  assign res.srtt     = srtt_nxt;
  assign res.rttvar   = rttvar_nxt;

endmodule

// ===== hw/rtl/path_rto_and_cwnd_control_unit.sv =====
// Data path: an accepted beat is held in the input register, and its result
//   is captured in the result register that drives the out_ ports.
// Throughput: one beat per cycle while out_stall is low; the single-pass update
//   of the path state (estimator, RTO clamp, window logic) sets the pace.
// Reset (rst_n low, synchronous): config registers return to their defaults,
//   path state loads the default initial RTO/cwnd/ssthresh, both stages empty.
// ----------------------------------------------------------------------------
// path_rto_and_cwnd_control_unit: per-path RTO estimation and cwnd control
// Input register -> state update logic -> result register, valid/stall both
// sides, APB-style register port for gains, RTO bounds, MTU and initials.
// ----------------------------------------------------------------------------
module path_rto_and_cwnd_control_unit import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  // event channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [31:0]       in_rtt_value,
  input  logic [31:0]       in_sack_cum_tsn,
  input  logic [31:0]       in_ack_point,
  input  logic [31:0]       in_newly_acked,
  input  logic [31:0]       in_outstanding,
  input  logic [31:0]       in_now,
  input  logic [31:0]       in_last_used_time,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_cwnd_out,
  output logic [31:0]       out_ssthresh_out,
  output logic [31:0]       out_pba_out,
  output logic [31:0]       out_rto_out,
  output logic [31:0]       out_srtt_out,
  output logic [31:0]       out_rttvar_out
);

  prc_cfg_t  cfg;
  prc_res_t  core_res;

  // input stage
  logic      in_valid_r, in_valid_nxt;
  prc_item_t in_item_r;
  // result stage
  logic      out_valid_r, out_valid_nxt;
  prc_res_t  out_res_r;

  logic      in_take;   // beat accepted into the input stage
  logic      advance;   // result stage free this cycle
  logic      step;      // input beat is applied to the path state

  assign cfg_pready = 1'b1;

  prc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  prc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  // The input register doubles as the skid stage: a new beat is taken while
  // the result register still waits, as long as the input stage is empty.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.command        <= in_command;
      in_item_r.rtt_value      <= in_rtt_value;
      in_item_r.sack_cum_tsn   <= in_sack_cum_tsn;
      in_item_r.ack_point      <= in_ack_point;
      in_item_r.newly_acked    <= in_newly_acked;
      in_item_r.outstanding    <= in_outstanding;
      in_item_r.now            <= in_now;
      in_item_r.last_used_time <= in_last_used_time;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cwnd_out     = out_res_r.cwnd;
  assign out_ssthresh_out = out_res_r.ssthresh;
  assign out_pba_out      = out_res_r.pba;
  assign out_rto_out      = out_res_r.rto;
  assign out_srtt_out     = out_res_r.srtt;
  assign out_rttvar_out   = out_res_r.rttvar;

endmodule
